// ===== rtl/hvdma_pkg.sv =====
// shared types and constants for the hblank video-memory dma controller
// no dependencies

package hvdma_pkg;

    // bytes moved per horizontal blank in hblank mode
    localparam int BLOCK_BYTES = 16;
    localparam int BBC_W = $clog2(BLOCK_BYTES) + 1;

    // action codes
    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // register select codes
    localparam logic [2:0] SEL_SRC_HI = 3'd0;
    localparam logic [2:0] SEL_SRC_LO = 3'd1;
    localparam logic [2:0] SEL_DST_HI = 3'd2;
    localparam logic [2:0] SEL_DST_LO = 3'd3;
    localparam logic [2:0] SEL_CTRL   = 3'd4;

    localparam logic [15:0] DST_WRAP_MASK = 16'h9FFF;
    localparam logic [7:0]  STATUS_DONE   = 8'hFF;
    localparam logic [7:0]  CANCEL_FLAG   = 8'h80;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'b0001,
        PH_XFER      = 4'b0010,
        PH_WAIT_HB   = 4'b0100,
        PH_WAIT_LINE = 4'b1000
    } phase_t;

    typedef struct packed {
        logic        copy_valid;
        logic [15:0] copy_src;
        logic [15:0] copy_dst;
        logic        status_valid;
        logic [7:0]  status_value;
        logic [7:0]  control_readback;
        logic        halt_cpu;
        logic        release_cpu;
    } res_t;

endpackage

// ===== rtl/hblank_vram_dma_controller_top.sv =====
// a word's result is registered, in the result register when that is free or being taken, else in the skid slot
// throughput: one word per cycle while the skid slot is empty; all state updates settle in the accept cycle
// a two-entry output buffer (result register plus skid) keeps req_ready high
// while a single result waits on rsp_ready
// reset (rst_n, async, active low): idle phase, general mode, addresses,
// length and block counter zero, output buffer empty
// depends on hvdma_pkg and hvdma_core

module hblank_vram_dma_controller_top
    import hvdma_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // request channel
    input  logic        req_valid,
    output logic        req_ready,
    input  logic        action,
    input  logic [2:0]  reg_select,
    input  logic [7:0]  write_data,
    input  logic        in_hblank,
    input  logic        cpu_running,

    // response channel
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic        copy_valid,
    output logic [15:0] copy_src,
    output logic [15:0] copy_dst,
    output logic        status_valid,
    output logic [7:0]  status_value,
    output logic [7:0]  control_readback,
    output logic        halt_cpu,
    output logic        release_cpu
);

    logic req_acc;
    logic rsp_take;
    res_t step_res;

    // result register and skid slot
    res_t out_reg;
    res_t skid_reg;
    logic out_valid_reg;
    logic skid_valid_reg;

    // ready only depends on the skid slot, so a stalled result does not block input
    assign req_ready = !skid_valid_reg;
    assign req_acc   = req_valid && req_ready;
    assign rsp_take  = out_valid_reg && rsp_ready;

    // state and step logic, updated at the accept edge
    hvdma_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (req_acc),
        .action      (action),
        .reg_select  (reg_select),
        .write_data  (write_data),
        .in_hblank   (in_hblank),
        .cpu_running (cpu_running),
        .result      (step_res)
    );

    // output buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || rsp_take)
        begin
            // result slot frees up: drain skid first, else take the new word
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= req_acc;
            end
        end
        else if (req_acc)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // output buffer payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || rsp_take)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (req_acc)
                out_reg <= step_res;
        end
        else if (req_acc)
        begin
            skid_reg <= step_res;
        end
    end

    assign rsp_valid        = out_valid_reg;
    assign copy_valid       = out_reg.copy_valid;
    assign copy_src         = out_reg.copy_src;
    assign copy_dst         = out_reg.copy_dst;
    assign status_valid     = out_reg.status_valid;
    assign status_value     = out_reg.status_value;
    assign control_readback = out_reg.control_readback;
    assign halt_cpu         = out_reg.halt_cpu;
    assign release_cpu      = out_reg.release_cpu;

`ifndef SYNTHESIS
    // skid slot only fills behind a held result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot valid without result register valid");

    // an accepted word always shows up in the buffer
    a_acc_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> rsp_valid)
        else $error("accepted word produced no response");

    // one step never both halts and releases the processor
    a_halt_release_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(halt_cpu && release_cpu))
        else $error("halt and release requested together");

    // addresses read as zero when no copy is requested
    a_copy_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !copy_valid) |-> (copy_src == 16'h0000 && copy_dst == 16'h0000))
        else $error("copy addresses nonzero without a copy");

    // status value reads as zero when no status write
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !status_valid) |-> (status_value == 8'h00))
        else $error("status value nonzero without a status write");
`endif

endmodule

// ===== rtl/hvdma_core.sv =====
// dma state registers and the single-pass step logic for one word
// depends on hvdma_pkg

module hvdma_core
    import hvdma_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_en,
    input  logic       action,
    input  logic [2:0] reg_select,
    input  logic [7:0] write_data,
    input  logic       in_hblank,
    input  logic       cpu_running,
    output res_t       result
);

    logic [15:0]      src_reg, src_next;
    logic [15:0]      dst_reg, dst_next;
    logic [11:0]      bytes_reg, bytes_next;
    logic             hbmode_reg, hbmode_next;
    phase_t           phase_reg, phase_next;
    logic [BBC_W-1:0] bbc_reg, bbc_next;

    logic [11:0]      new_len;
    logic [11:0]      bytes_dec;
    logic [BBC_W-1:0] bbc_inc;
    logic [15:0]      dst_inc;

    assign new_len   = {({1'b0, write_data[6:0]} + 8'd1), 4'h0};
    assign bytes_dec = bytes_reg - 12'd1;
    assign bbc_inc   = bbc_reg + BBC_W'(1);
    assign dst_inc   = dst_reg + 16'd1;

    always_comb
    begin
        src_next    = src_reg;
        dst_next    = dst_reg;
        bytes_next  = bytes_reg;
        hbmode_next = hbmode_reg;
        phase_next  = phase_reg;
        bbc_next    = bbc_reg;
        result      = '0;
        if (action == ACT_WRITE)
        begin
            unique case (reg_select)
                SEL_SRC_HI: src_next = {write_data, src_reg[7:0]};
                SEL_SRC_LO: src_next = {src_reg[15:8], write_data[7:4], 4'h0};
                SEL_DST_HI: dst_next = {3'b100, write_data[4:0], dst_reg[7:0]};
                SEL_DST_LO: dst_next = {dst_reg[15:8], write_data[7:4], 4'h0};
                SEL_CTRL:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        bytes_next  = new_len;
                        hbmode_next = write_data[7];
                        if (!write_data[7])
                        begin
                            result.halt_cpu = 1'b1;
                            phase_next      = PH_XFER;
                        end
                        else
                        begin
                            phase_next = PH_WAIT_HB;
                        end
                        result.control_readback = {1'b0, write_data[6:0]};
                    end
                    else if (write_data[7])
                    begin
                        // cancel, block counter kept
                        phase_next = PH_IDLE;
                        result.control_readback = CANCEL_FLAG | (bytes_reg[11:4] - 8'd1);
                    end
                    else
                    begin
                        bytes_next = new_len;
                        result.control_readback = {1'b0, write_data[6:0]};
                    end
                end
                default: ;
            endcase
        end
        else
        begin
            unique case (phase_reg)
                PH_XFER:
                begin
                    if (bytes_reg != 12'd0)
                    begin
                        result.copy_valid = 1'b1;
                        result.copy_src   = src_reg;
                        result.copy_dst   = dst_reg;
                        src_next   = src_reg + 16'd1;
                        dst_next   = dst_inc & DST_WRAP_MASK;
                        bytes_next = bytes_dec;
                        if (bytes_dec[3:0] == 4'h0)
                        begin
                            result.status_valid = 1'b1;
                            result.status_value = bytes_dec[11:4] - 8'd1;
                        end
                        if (hbmode_reg)
                        begin
                            if (bbc_inc == BBC_W'(BLOCK_BYTES))
                            begin
                                bbc_next           = '0;
                                phase_next         = PH_WAIT_LINE;
                                result.release_cpu = 1'b1;
                            end
                            else
                            begin
                                bbc_next = bbc_inc;
                            end
                        end
                    end
                    else
                    begin
                        src_next            = 16'hFFFF;
                        dst_next            = 16'hFFFF;
                        result.status_valid = 1'b1;
                        result.status_value = STATUS_DONE;
                        result.release_cpu  = 1'b1;
                        phase_next          = PH_IDLE;
                    end
                end
                PH_WAIT_HB:
                begin
                    if (in_hblank && cpu_running)
                    begin
                        phase_next      = PH_XFER;
                        result.halt_cpu = 1'b1;
                    end
                end
                PH_WAIT_LINE:
                begin
                    if (!in_hblank)
                        phase_next = PH_WAIT_HB;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg    <= '0;
            dst_reg    <= '0;
            bytes_reg  <= '0;
            hbmode_reg <= 1'b0;
            phase_reg  <= PH_IDLE;
            bbc_reg    <= '0;
        end
        else if (step_en)
        begin
            src_reg    <= src_next;
            dst_reg    <= dst_next;
            bytes_reg  <= bytes_next;
            hbmode_reg <= hbmode_next;
            phase_reg  <= phase_next;
            bbc_reg    <= bbc_next;
        end
    end

endmodule

// ===== test/tb_hblank_vram_dma_controller_top.sv =====
// self-checking testbench for hblank_vram_dma_controller_top
// depends on hvdma_pkg and the rtl of the dma controller; runs on its own

module tb_hblank_vram_dma_controller_top;
    import hvdma_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_WORDS = 1900;
    localparam int QUIET_WORDS  = 200;      // last words run with no idling on either side
    localparam int GUARD_TICKS  = 600;      // ticks allowed per transfer before forcing a cancel
    localparam int DRAIN_CYCLES = 8;
    localparam int TIMEOUT_NS   = 5_000_000;

    // register selects the block ignores
    localparam logic [2:0] SEL_UNUSED_LO = 3'd5;
    localparam logic [2:0] SEL_UNUSED_HI = 3'd7;

    // results that can be read straight off the register map
    localparam res_t RES_NONE = '0;
    localparam res_t RES_HALT = '{1'b0, 16'h0000, 16'h0000, 1'b0, 8'h00, 8'h00, 1'b1, 1'b0};
    localparam res_t RES_DONE = '{1'b0, 16'h0000, 16'h0000, 1'b1, STATUS_DONE, 8'h00,
                                  1'b0, 1'b1};

    // one directed row: the word, how many times it is sent, and an optional typed result
    typedef struct packed {
        logic       act;
        logic [2:0] sel;
        logic [7:0] data;
        logic       hb;
        logic       run;
        logic [4:0] reps;
        logic       typed;
        res_t       want;
    } dir_row_t;

    localparam int N_ROWS = 17;
    localparam dir_row_t STIM_TABLE [N_ROWS] = '{
        // tick while idle, hblank and cpu flags high: nothing happens
        '{ACT_TICK,  SEL_SRC_HI,    8'h00, 1'b1, 1'b1, 5'd1,  1'b1, RES_NONE},
        // unused register selects are ignored
        '{ACT_WRITE, SEL_UNUSED_LO, 8'hFF, 1'b0, 1'b0, 5'd1,  1'b1, RES_NONE},
        '{ACT_WRITE, SEL_UNUSED_HI, 8'h00, 1'b1, 1'b1, 5'd1,  1'b1, RES_NONE},
        // all-ones addresses: src fff0, dst 9ff0
        '{ACT_WRITE, SEL_SRC_HI,    8'hFF, 1'b0, 1'b0, 5'd1,  1'b1, RES_NONE},
        '{ACT_WRITE, SEL_SRC_LO,    8'hFF, 1'b0, 1'b0, 5'd1,  1'b1, RES_NONE},
        '{ACT_WRITE, SEL_DST_HI,    8'hFF, 1'b0, 1'b0, 5'd1,  1'b1, RES_NONE},
        '{ACT_WRITE, SEL_DST_LO,    8'hFF, 1'b0, 1'b0, 5'd1,  1'b1, RES_NONE},
        // shortest general transfer: halts the cpu
        '{ACT_WRITE, SEL_CTRL,      8'h00, 1'b0, 1'b0, 5'd1,  1'b1, RES_HALT},
        // sixteen copies, source and destination both wrap
        '{ACT_TICK,  SEL_SRC_HI,    8'h00, 1'b0, 1'b0, 5'd16, 1'b0, RES_NONE},
        // nothing left: done status and release
        '{ACT_TICK,  SEL_SRC_HI,    8'h00, 1'b0, 1'b0, 5'd1,  1'b1, RES_DONE},
        // longest hblank transfer
        '{ACT_WRITE, SEL_CTRL,      8'hFF, 1'b0, 1'b0, 5'd1,  1'b1,
          '{1'b0, 16'h0000, 16'h0000, 1'b0, 8'h00, 8'h7F, 1'b0, 1'b0}},
        // block starts only with hblank and a running cpu
        '{ACT_TICK,  SEL_SRC_HI,    8'h00, 1'b1, 1'b0, 5'd1,  1'b1, RES_NONE},
        '{ACT_TICK,  SEL_SRC_HI,    8'h00, 1'b0, 1'b1, 5'd1,  1'b1, RES_NONE},
        '{ACT_TICK,  SEL_SRC_HI,    8'h00, 1'b1, 1'b1, 5'd1,  1'b1, RES_HALT},
        // reload while active keeps the mode
        '{ACT_WRITE, SEL_CTRL,      8'h05, 1'b0, 1'b0, 5'd1,  1'b1,
          '{1'b0, 16'h0000, 16'h0000, 1'b0, 8'h00, 8'h05, 1'b0, 1'b0}},
        // cancel while active reads back the remaining blocks
        '{ACT_WRITE, SEL_CTRL,      8'h80, 1'b0, 1'b0, 5'd1,  1'b0, RES_NONE},
        // cancel gives no release, block is idle again
        '{ACT_TICK,  SEL_SRC_HI,    8'h00, 1'b1, 1'b1, 5'd1,  1'b1, RES_NONE}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        req_valid = 1'b0;
    logic        req_ready;
    logic        action = ACT_TICK;
    logic [2:0]  reg_select = SEL_SRC_HI;
    logic [7:0]  write_data = 8'h00;
    logic        in_hblank = 1'b0;
    logic        cpu_running = 1'b0;

    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    logic        copy_valid;
    logic [15:0] copy_src;
    logic [15:0] copy_dst;
    logic        status_valid;
    logic [7:0]  status_value;
    logic [7:0]  control_readback;
    logic        halt_cpu;
    logic        release_cpu;

    // predicted dma state, updated as each word is queued
    logic [15:0]      dma_src = '0;
    logic [15:0]      dma_dst = '0;
    logic [11:0]      dma_left = '0;
    logic             dma_hb_mode = 1'b0;
    phase_t           dma_phase = PH_IDLE;
    logic [BBC_W-1:0] dma_blk = '0;

    res_t dma_results_due [$];
    int   words_sent = 0;
    bit   counting = 1'b1;
    bit   quiet = 1'b0;
    int   mismatches = 0;

    hblank_vram_dma_controller_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_ready        (req_ready),
        .action           (action),
        .reg_select       (reg_select),
        .write_data       (write_data),
        .in_hblank        (in_hblank),
        .cpu_running      (cpu_running),
        .rsp_valid        (rsp_valid),
        .rsp_ready        (rsp_ready),
        .copy_valid       (copy_valid),
        .copy_src         (copy_src),
        .copy_dst         (copy_dst),
        .status_valid     (status_valid),
        .status_value     (status_value),
        .control_readback (control_readback),
        .halt_cpu         (halt_cpu),
        .release_cpu      (release_cpu)
    );

    always #(CLK_HALF) clk = ~clk;

    // result of one word and the state change it causes
    task automatic compute_dma_result(input logic act, input logic [2:0] sel,
                                      input logic [7:0] data, input logic hb,
                                      input logic run, output res_t r);
        r = '0;
        if (act == ACT_WRITE) begin
            case (sel)
                SEL_SRC_HI: dma_src[15:8] = data;
                SEL_SRC_LO: dma_src[7:0] = data & 8'hF0;
                SEL_DST_HI: dma_dst[15:8] = {3'b100, data[4:0]};
                SEL_DST_LO: dma_dst[7:0] = data & 8'hF0;
                SEL_CTRL:
                begin
                    if (dma_phase == PH_IDLE) begin
                        dma_left = {({1'b0, data[6:0]} + 8'd1), 4'b0000};
                        dma_hb_mode = data[7];
                        if (!data[7]) begin
                            r.halt_cpu = 1'b1;
                            dma_phase = PH_XFER;
                        end
                        else begin
                            dma_phase = PH_WAIT_HB;
                        end
                        r.control_readback = {1'b0, data[6:0]};
                    end
                    else if (data[7]) begin
                        // cancel: block counter kept, no release
                        dma_phase = PH_IDLE;
                        r.control_readback = CANCEL_FLAG | (dma_left[11:4] - 8'd1);
                    end
                    else begin
                        dma_left = {({1'b0, data[6:0]} + 8'd1), 4'b0000};
                        r.control_readback = {1'b0, data[6:0]};
                    end
                end
                default: ;
            endcase
        end
        else begin
            case (dma_phase)
                PH_XFER:
                begin
                    if (dma_left != 12'd0) begin
                        r.copy_valid = 1'b1;
                        r.copy_src = dma_src;
                        r.copy_dst = dma_dst;
                        dma_src = dma_src + 16'd1;
                        dma_dst = (dma_dst + 16'd1) & DST_WRAP_MASK;
                        dma_left = dma_left - 12'd1;
                        if (dma_left[3:0] == 4'd0) begin
                            r.status_valid = 1'b1;
                            r.status_value = dma_left[11:4] - 8'd1;
                        end
                        if (dma_hb_mode) begin
                            dma_blk = dma_blk + BBC_W'(1);
                            if (dma_blk == BBC_W'(BLOCK_BYTES)) begin
                                dma_blk = '0;
                                dma_phase = PH_WAIT_LINE;
                                r.release_cpu = 1'b1;
                            end
                        end
                    end
                    else begin
                        dma_src = 16'hFFFF;
                        dma_dst = 16'hFFFF;
                        r.status_valid = 1'b1;
                        r.status_value = STATUS_DONE;
                        dma_phase = PH_IDLE;
                        r.release_cpu = 1'b1;
                    end
                end
                PH_WAIT_HB:
                begin
                    if (hb && run) begin
                        dma_phase = PH_XFER;
                        r.halt_cpu = 1'b1;
                    end
                end
                PH_WAIT_LINE:
                begin
                    if (!hb)
                        dma_phase = PH_WAIT_HB;
                end
                default: ;
            endcase
        end
    endtask

    // queue the expected result, then offer the word until it is taken
    task automatic send_word(input logic act, input logic [2:0] sel, input logic [7:0] data,
                             input logic hb, input logic run, input logic typed,
                             input res_t want);
        res_t r;
        compute_dma_result(act, sel, data, hb, run, r);
        dma_results_due.push_back(typed ? want : r);
        if (counting)
            words_sent++;
        // random idle burst before this word
        if (!quiet && $urandom_range(0, 7) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_valid   <= 1'b1;
        action      <= act;
        reg_select  <= sel;
        write_data  <= data;
        in_hblank   <= hb;
        cpu_running <= run;
        do @(posedge clk); while (req_ready !== 1'b1);
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'hFF;
            1: return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    // tick with random line flags; select and data bits are don't-care on ticks
    task automatic send_tick();
        send_word(ACT_TICK, 3'($urandom_range(0, 7)), 8'($urandom),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 3) != 0), 1'b0, RES_NONE);
    endtask

    task automatic send_reg(input logic [2:0] sel, input logic [7:0] data);
        send_word(ACT_WRITE, sel, data, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'b0, RES_NONE);
    endtask

    // register write in the middle of a transfer: address change, reload or cancel
    task automatic meddle();
        case ($urandom_range(0, 2))
            0: send_reg(3'($urandom_range(0, 3)), rand_byte());
            1: send_reg(SEL_CTRL, {1'b0, 7'($urandom_range(0, 3))});
            default: send_reg(SEL_CTRL, {1'b1, 7'($urandom)});
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // response side: check each accepted result, stall rsp_ready in random bursts
    initial begin
        int   stall;
        res_t want;
        stall = 0;
        forever begin
            @(posedge clk);
            if (rsp_valid === 1'b1 && rsp_ready) begin
                if (dma_results_due.size() == 0) begin
                    $error("result word with nothing due");
                    mismatches++;
                end
                else begin
                    want = dma_results_due.pop_front();
                    check_field("copy_valid", 16'(want.copy_valid), 16'(copy_valid));
                    check_field("copy_src", want.copy_src, copy_src);
                    check_field("copy_dst", want.copy_dst, copy_dst);
                    check_field("status_valid", 16'(want.status_valid), 16'(status_valid));
                    check_field("status_value", 16'(want.status_value), 16'(status_value));
                    check_field("control_readback", 16'(want.control_readback),
                                16'(control_readback));
                    check_field("halt_cpu", 16'(want.halt_cpu), 16'(halt_cpu));
                    check_field("release_cpu", 16'(want.release_cpu), 16'(release_cpu));
                end
            end
            if (stall > 0) begin
                stall--;
                rsp_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(0, 3);
                rsp_ready <= 1'b0;
            end
            else begin
                rsp_ready <= 1'b1;
            end
        end
    end

    // request side: reset, directed table, then random transfer sequences
    initial begin
        int guard;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_ROWS; i++) begin
            repeat (STIM_TABLE[i].reps)
                send_word(STIM_TABLE[i].act, STIM_TABLE[i].sel, STIM_TABLE[i].data,
                          STIM_TABLE[i].hb, STIM_TABLE[i].run, STIM_TABLE[i].typed,
                          STIM_TABLE[i].want);
        end

        while (words_sent < RANDOM_WORDS) begin
            quiet = (words_sent > RANDOM_WORDS - QUIET_WORDS);
            guard = 0;
            case ($urandom_range(0, 9))
                // address setup with random content
                0, 1: repeat (4) send_reg(3'($urandom_range(0, 3)), rand_byte());
                // general transfer, mostly short, now and then longer
                2, 3, 4:
                begin
                    send_reg(SEL_CTRL, {1'b0, ($urandom_range(0, 15) == 0) ?
                             7'($urandom_range(4, 31)) : 7'($urandom_range(0, 3))});
                    while (dma_phase != PH_IDLE && guard < GUARD_TICKS) begin
                        if ($urandom_range(0, 39) == 0)
                            meddle();
                        else
                            send_tick();
                        guard++;
                    end
                end
                // hblank transfer over a few lines
                5, 6, 7:
                begin
                    send_reg(SEL_CTRL, {1'b1, ($urandom_range(0, 15) == 0) ?
                             7'($urandom_range(3, 7)) : 7'($urandom_range(0, 2))});
                    while (dma_phase != PH_IDLE && guard < GUARD_TICKS) begin
                        if ($urandom_range(0, 59) == 0)
                            meddle();
                        else
                            send_tick();
                        guard++;
                    end
                end
                // run a short transfer dry, then cancel with nothing remaining
                8:
                begin
                    send_reg(SEL_CTRL, {1'b0, 7'($urandom_range(0, 1))});
                    while (dma_phase == PH_XFER && dma_left != 12'd0)
                        send_tick();
                    if (dma_phase == PH_XFER)
                        send_reg(SEL_CTRL, {1'b1, 7'($urandom)});
                end
                // noise: any word at all
                default:
                begin
                    counting = 1'b0;
                    repeat ($urandom_range(1, 6))
                        send_word(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                                  8'($urandom), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)), 1'b0, RES_NONE);
                    counting = 1'b1;
                end
            endcase
            // a transfer that outlived its guard is cancelled
            if (guard >= GUARD_TICKS && dma_phase != PH_IDLE)
                send_reg(SEL_CTRL, CANCEL_FLAG);
        end

        req_valid <= 1'b0;
        quiet = 1'b1;
        while (dma_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("hblank_vram_dma_controller_top test passed");
        else
            $display("hblank_vram_dma_controller_top test failed");
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("hblank_vram_dma_controller_top test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/hvdma_pkg.sv
rtl/hvdma_core.sv
rtl/hblank_vram_dma_controller_top.sv
test/tb_hblank_vram_dma_controller_top.sv
